// ===== hdl/i2cseq_pkg.sv =====
package i2cseq_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [1:0] {
        KIND_LOAD     = 2'd0,
        KIND_START    = 2'd1,
        KIND_TX_READY = 2'd2,
        KIND_RX_BYTE  = 2'd3
    } kind_t;

    // classified event handed from the front end to the sequencer
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [4:0]  load_slot;
        logic        load_en;
        logic [6:0]  device_address;
        logic [7:0]  register_address;
        logic [5:0]  count;
        logic        is_read;
    } cmd_t;

    typedef struct packed {
        logic        send_start;
        logic [6:0]  target_address;
        logic        byte_out_valid;
        logic [7:0]  byte_out;
        logic        repeated_start;
        logic        send_stop;
        logic        got_valid;
        logic [4:0]  got_index;
        logic [7:0]  got_byte;
        logic        finished;
        logic [2:0]  phase;
    } res_t;

endpackage

// ===== hdl/i2cseq_front.sv =====
module i2cseq_front #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic [1:0]         mode,
    input  logic [7:0]         data_byte,
    input  logic [4:0]         load_slot,
    input  logic [6:0]         device_address,
    input  logic [7:0]         register_address,
    input  logic [5:0]         byte_count,
    input  logic               is_read,
    output i2cseq_pkg::cmd_t   cmd
);

    always_comb begin
        cmd.kind             = i2cseq_pkg::kind_t'(mode);
        cmd.data_byte        = data_byte;
        cmd.load_slot        = load_slot;
        // drop loads beyond the buffer
        cmd.load_en          = (32'(load_slot) < BUFFER_DEPTH);
        cmd.device_address   = device_address;
        cmd.register_address = register_address;
        cmd.is_read          = is_read;
        if (32'(byte_count) > BUFFER_DEPTH) begin
            cmd.count = 6'(BUFFER_DEPTH);
        end else begin
            cmd.count = byte_count;
        end
    end

endmodule

// ===== hdl/i2cseq_queue.sv =====
module i2cseq_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  i2cseq_pkg::cmd_t   push_cmd,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output i2cseq_pkg::cmd_t   head_cmd
);

    i2cseq_pkg::cmd_t entry_reg [i2cseq_pkg::QUEUE_DEPTH];

    logic [i2cseq_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [i2cseq_pkg::QUEUE_CNT_W-1:0] count_reg;
    logic do_push, do_pop;

    assign full      = (count_reg == i2cseq_pkg::QUEUE_CNT_W'(i2cseq_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== hdl/i2cseq_back.sv =====
module i2cseq_back #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    input  i2cseq_pkg::cmd_t   cmd,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output i2cseq_pkg::res_t   out_res
);

    localparam int STORE_DEPTH = (BUFFER_DEPTH < 32) ? BUFFER_DEPTH : 32;
    localparam int IDX_W       = $clog2(STORE_DEPTH);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_ADDR   = 3'd1,
        PH_SWITCH = 3'd2,
        PH_TXDATA = 3'd3,
        PH_RX     = 3'd4
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  saved_reg, saved_next;
    logic [5:0]  rx_left_reg, rx_left_next;
    logic [5:0]  tx_left_reg, tx_left_next;
    logic [4:0]  rx_pos_reg, rx_pos_next;
    logic [4:0]  tx_pos_reg, tx_pos_next;
    logic        out_valid_reg;
    i2cseq_pkg::res_t out_res_reg, res;

    logic [7:0]  store [STORE_DEPTH];
    logic [7:0]  store_byte_reg;
    logic [4:0]  store_rd_addr;
    logic        store_wr_en;
    logic [5:0]  rx_left_after;

    assign pop       = cmd_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    assign store_wr_en   = pop && cmd.kind == i2cseq_pkg::KIND_LOAD && cmd.load_en;
    // read ahead at the transmit position the next cycle will hold
    assign store_rd_addr = !aresetn ? 5'd0 : (pop ? tx_pos_next : tx_pos_reg);

    always_ff @(posedge aclk) begin
        if (store_wr_en) begin
            store[cmd.load_slot[IDX_W-1:0]] <= cmd.data_byte;
        end
        if (32'(store_rd_addr) >= STORE_DEPTH) begin
            store_byte_reg <= '0;
        end else if (store_wr_en && cmd.load_slot == store_rd_addr) begin
            // pass a same-cycle load straight through
            store_byte_reg <= cmd.data_byte;
        end else begin
            store_byte_reg <= store[store_rd_addr[IDX_W-1:0]];
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        saved_next    = saved_reg;
        rx_left_next  = rx_left_reg;
        tx_left_next  = tx_left_reg;
        rx_pos_next   = rx_pos_reg;
        tx_pos_next   = tx_pos_reg;
        rx_left_after = rx_left_reg;
        res           = '0;
        unique case (cmd.kind)
            i2cseq_pkg::KIND_LOAD: begin
            end
            i2cseq_pkg::KIND_START: begin
                // a start always abandons whatever is in flight
                phase_next = PH_ADDR;
                saved_next = cmd.register_address;
                if (cmd.is_read) begin
                    rx_left_next = cmd.count;
                    tx_left_next = '0;
                end else begin
                    tx_left_next = cmd.count;
                    rx_left_next = '0;
                end
                rx_pos_next        = '0;
                tx_pos_next        = '0;
                res.send_start     = 1'b1;
                res.target_address = cmd.device_address;
            end
            i2cseq_pkg::KIND_TX_READY: begin
                unique case (phase_reg)
                    PH_ADDR: begin
                        res.byte_out_valid = 1'b1;
                        res.byte_out       = saved_reg;
                        phase_next = (rx_left_reg != '0) ? PH_SWITCH : PH_TXDATA;
                    end
                    PH_SWITCH: begin
                        res.repeated_start = 1'b1;
                        res.send_stop      = (rx_left_reg == 6'd1);
                        phase_next         = PH_RX;
                    end
                    PH_TXDATA: begin
                        if (tx_left_reg != '0) begin
                            res.byte_out_valid = 1'b1;
                            res.byte_out       = store_byte_reg;
                            tx_pos_next        = tx_pos_reg + 5'd1;
                            tx_left_next       = tx_left_reg - 6'd1;
                        end else begin
                            res.send_stop = 1'b1;
                            res.finished  = 1'b1;
                            phase_next    = PH_IDLE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            i2cseq_pkg::KIND_RX_BYTE: begin
                if (phase_reg == PH_RX) begin
                    if (rx_left_reg != '0) begin
                        res.got_valid = 1'b1;
                        res.got_index = rx_pos_reg;
                        res.got_byte  = cmd.data_byte;
                        rx_pos_next   = rx_pos_reg + 5'd1;
                        rx_left_after = rx_left_reg - 6'd1;
                    end
                    rx_left_next = rx_left_after;
                    // stop goes out ahead of the final byte
                    if (rx_left_after == 6'd1) begin
                        res.send_stop = 1'b1;
                    end else if (rx_left_after == '0) begin
                        res.finished = 1'b1;
                        phase_next   = PH_IDLE;
                    end
                end
            end
            default: begin
            end
        endcase
        res.phase = 3'(phase_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            saved_reg     <= '0;
            rx_left_reg   <= '0;
            tx_left_reg   <= '0;
            rx_pos_reg    <= '0;
            tx_pos_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                phase_reg     <= phase_next;
                saved_reg     <= saved_next;
                rx_left_reg   <= rx_left_next;
                tx_left_reg   <= tx_left_next;
                rx_pos_reg    <= rx_pos_next;
                tx_pos_reg    <= tx_pos_next;
                out_valid_reg <= 1'b1;
                out_res_reg   <= res;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_one_direction: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rx_left_reg != '0 && tx_left_reg != '0))
        else $error("read and write counts both pending");

    a_start_to_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && cmd.kind == i2cseq_pkg::KIND_START |=> phase_reg == PH_ADDR)
        else $error("start did not enter address phase");

    a_finish_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && res.finished |=> phase_reg == PH_IDLE && out_res_reg.phase == 3'(PH_IDLE))
        else $error("finished beat without return to idle");

    a_rx_only_in_rx: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && res.got_valid |-> phase_reg == PH_RX)
        else $error("byte delivered outside receive phase");

endmodule

// ===== hdl/i2c_register_transaction_sequencer_unit.sv =====
// I2C master register access sequencer.
// Slave channel: one event per beat. s_tuser carries the event kind (load a
// transmit byte, start a transaction, transmit ready, byte received);
// s_tdata carries the payload fields. Master channel: exactly one result
// beat per input beat, in order; m_tlast marks the beat that completes a
// transaction and returns the sequencer to idle.
// An accepted input beat is written into the event queue; the execution
// stage pops it from the queue head and its result is registered in the
// output register.
// Throughput: one beat per cycle while the receiver takes results; each
// event updates the phase counters and the transmit buffer in the execution stage.
// A four-entry event queue separates intake from execution, so s_tready
// stays high while the receiver stalls until the queue fills; a stalled
// result holds in the output register.
// Reset (aresetn low, synchronous) empties the queue, drops any pending
// result and returns the sequencer to idle with zero counts. Transmit buffer
// contents are not cleared and must be loaded before they are sent.
module i2c_register_transaction_sequencer_unit #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // data_byte[7:0], load_slot[12:8], device_address[19:13],
    // register_address[27:20], byte_count[33:28], is_read[34], zero fill
    input  logic [i2cseq_pkg::IN_DATA_W-1:0]  s_tdata,
    // mode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // send_start[0], target_address[7:1], byte_out_valid[8], byte_out[16:9],
    // repeated_start[17], send_stop[18], got_valid[19], got_index[24:20],
    // got_byte[32:25], phase[35:33], zero fill
    output logic [i2cseq_pkg::OUT_DATA_W-1:0] m_tdata,
    // finished
    output logic        m_tlast
);

    i2cseq_pkg::cmd_t in_cmd, head_cmd;
    i2cseq_pkg::res_t res;
    logic q_full, q_not_empty, q_pop;

    i2cseq_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_front (
        .mode             (s_tuser),
        .data_byte        (s_tdata[7:0]),
        .load_slot        (s_tdata[12:8]),
        .device_address   (s_tdata[19:13]),
        .register_address (s_tdata[27:20]),
        .byte_count       (s_tdata[33:28]),
        .is_read          (s_tdata[34]),
        .cmd              (in_cmd)
    );

    i2cseq_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid),
        .push_cmd  (in_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    i2cseq_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_not_empty),
        .cmd       (head_cmd),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign s_tready = !q_full;
    assign m_tlast  = res.finished;
    assign m_tdata  = {4'b0000, res.phase, res.got_byte, res.got_index, res.got_valid,
                       res.send_stop, res.repeated_start, res.byte_out,
                       res.byte_out_valid, res.target_address, res.send_start};

endmodule

// ===== test/tb_i2c_register_transaction_sequencer_unit.sv =====
`timescale 1ns / 1ps

module tb_i2c_register_transaction_sequencer_unit;

    typedef i2cseq_pkg::kind_t kind_t;
    typedef i2cseq_pkg::res_t  res_t;

    localparam kind_t KIND_LOAD     = i2cseq_pkg::KIND_LOAD;
    localparam kind_t KIND_START    = i2cseq_pkg::KIND_START;
    localparam kind_t KIND_TX_READY = i2cseq_pkg::KIND_TX_READY;
    localparam kind_t KIND_RX_BYTE  = i2cseq_pkg::KIND_RX_BYTE;

    localparam int BUF_DEPTH   = 32;
    localparam int ITEM_TARGET = 700;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 90;
    localparam int TAIL_CYCLES = 10;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_ADDR   = 3'd1,
        PH_SWITCH = 3'd2,
        PH_TXDATA = 3'd3,
        PH_RX     = 3'd4
    } seq_phase_t;

    typedef struct {
        kind_t       kind;
        logic [39:0] payload;
        bit          typed;
        res_t        want;
    } stim_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    kind_t       s_tuser  = KIND_LOAD;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    // sequencer state as the predictor sees it
    seq_phase_t  seq_ph    = PH_IDLE;
    logic [7:0]  saved_reg = '0;
    logic [5:0]  rx_left   = '0;
    logic [5:0]  tx_left   = '0;
    logic [4:0]  rx_pos    = '0;
    logic [4:0]  tx_pos    = '0;
    logic [7:0]  tx_store  [BUF_DEPTH];
    bit          tx_loaded [BUF_DEPTH];

    res_t pending_results[$];

    int events_sent      = 0;
    int effective_events = 0;
    int tx_bytes         = 0;
    int rx_bytes         = 0;
    int done_count       = 0;
    int beats_seen       = 0;
    int mismatches       = 0;
    int idle_cycles      = 0;
    int burst_left       = 0;

    i2c_register_transaction_sequencer_unit #(
        .BUFFER_DEPTH(BUF_DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [39:0] pack_event(input logic [7:0] data, input logic [4:0] slot,
                                               input logic [6:0] dev, input logic [7:0] regb,
                                               input logic [5:0] cnt, input logic rd);
        return {5'b0, rd, cnt, regb, dev, slot, data};
    endfunction

    function automatic logic [39:0] rand_payload();
        return {5'b0, 3'($urandom), 32'($urandom)};
    endfunction

    function automatic res_t quiet_result(input seq_phase_t ph);
        res_t r;
        r = '0;
        r.phase = ph;
        return r;
    endfunction

    function automatic res_t start_result(input logic [6:0] dev);
        res_t r;
        r = quiet_result(PH_ADDR);
        r.send_start = 1'b1;
        r.target_address = dev;
        return r;
    endfunction

    function automatic stim_row_t row(input kind_t k, input logic [39:0] p);
        stim_row_t s;
        s.kind = k;
        s.payload = p;
        s.typed = 1'b0;
        s.want = '0;
        return s;
    endfunction

    function automatic stim_row_t row_want(input kind_t k, input logic [39:0] p, input res_t w);
        stim_row_t s;
        s = row(k, p);
        s.typed = 1'b1;
        s.want = w;
        return s;
    endfunction

    // advance the sequencer by one event and return the beat it should produce
    function automatic res_t sequence_step(input kind_t k, input logic [39:0] p,
                                           output bit effective);
        res_t       r;
        logic [5:0] n;
        r = '0;
        effective = 1'b1;
        case (k)
            KIND_LOAD: begin
                tx_store[p[12:8]] = p[7:0];
                tx_loaded[p[12:8]] = 1'b1;
            end
            KIND_START: begin
                n = (p[33:28] > BUF_DEPTH) ? 6'(BUF_DEPTH) : p[33:28];
                seq_ph = PH_ADDR;
                saved_reg = p[27:20];
                rx_left = p[34] ? n : 6'd0;
                tx_left = p[34] ? 6'd0 : n;
                rx_pos = '0;
                tx_pos = '0;
                r.send_start = 1'b1;
                r.target_address = p[19:13];
            end
            KIND_TX_READY: begin
                case (seq_ph)
                    PH_ADDR: begin
                        r.byte_out_valid = 1'b1;
                        r.byte_out = saved_reg;
                        seq_ph = (rx_left != 6'd0) ? PH_SWITCH : PH_TXDATA;
                    end
                    PH_SWITCH: begin
                        r.repeated_start = 1'b1;
                        r.send_stop = (rx_left == 6'd1);
                        seq_ph = PH_RX;
                    end
                    PH_TXDATA: begin
                        if (tx_left != 6'd0) begin
                            r.byte_out_valid = 1'b1;
                            r.byte_out = tx_store[tx_pos];
                            tx_pos++;
                            tx_left--;
                        end else begin
                            r.send_stop = 1'b1;
                            r.finished = 1'b1;
                            seq_ph = PH_IDLE;
                        end
                    end
                    default: effective = 1'b0;
                endcase
            end
            default: begin
                if (seq_ph == PH_RX) begin
                    if (rx_left != 6'd0) begin
                        r.got_valid = 1'b1;
                        r.got_index = rx_pos;
                        r.got_byte = p[7:0];
                        rx_pos++;
                        rx_left--;
                    end
                    if (rx_left == 6'd1) begin
                        r.send_stop = 1'b1;
                    end else if (rx_left == 6'd0) begin
                        r.finished = 1'b1;
                        seq_ph = PH_IDLE;
                    end
                end else begin
                    effective = 1'b0;
                end
            end
        endcase
        r.phase = seq_ph;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        mismatches++;
        $display("[%0t] beat %0d: %s is 0x%0h, expected 0x%0h",
                 $time, beats_seen, what, got, want);
    endtask

    task automatic check_beat(input logic [39:0] d, input logic last);
        res_t want;
        beats_seen++;
        if (pending_results.size() == 0) begin
            flag_mismatch("beat with nothing pending", 1, 0);
            return;
        end
        want = pending_results.pop_front();
        if (d[0] !== want.send_start)
            flag_mismatch("send_start", d[0], want.send_start);
        if (d[7:1] !== want.target_address)
            flag_mismatch("target_address", d[7:1], want.target_address);
        if (d[8] !== want.byte_out_valid)
            flag_mismatch("byte_out_valid", d[8], want.byte_out_valid);
        if (d[16:9] !== want.byte_out)
            flag_mismatch("byte_out", d[16:9], want.byte_out);
        if (d[17] !== want.repeated_start)
            flag_mismatch("repeated_start", d[17], want.repeated_start);
        if (d[18] !== want.send_stop)
            flag_mismatch("send_stop", d[18], want.send_stop);
        if (d[19] !== want.got_valid)
            flag_mismatch("got_valid", d[19], want.got_valid);
        if (d[24:20] !== want.got_index)
            flag_mismatch("got_index", d[24:20], want.got_index);
        if (d[32:25] !== want.got_byte)
            flag_mismatch("got_byte", d[32:25], want.got_byte);
        if (last !== want.finished)
            flag_mismatch("finished", last, want.finished);
        if (d[35:33] !== want.phase)
            flag_mismatch("phase", d[35:33], want.phase);
    endtask

    // offer one beat, wait for it to be taken, then log what it should cause
    task automatic push_event(input kind_t k, input logic [39:0] p, input bit typed,
                              input res_t want);
        res_t        r;
        bit          effective;
        int          gap;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else if (roll < 55) begin
            gap = 0;
        end else if (roll < 92) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 30);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= p;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = sequence_step(k, p, effective);
        pending_results.push_back(typed ? want : r);
        events_sent++;
        if (effective) effective_events++;
        tx_bytes += r.byte_out_valid;
        rx_bytes += r.got_valid;
        done_count += r.finished;
    endtask

    // a buffer slot is never sent before it has been loaded
    task automatic offer(input kind_t k, input logic [39:0] p);
        logic [39:0] fill;
        if (k == KIND_TX_READY && seq_ph == PH_TXDATA && tx_left != 6'd0
                && !tx_loaded[tx_pos]) begin
            fill = rand_payload();
            fill[12:8] = tx_pos;
            push_event(KIND_LOAD, fill, 1'b0, '0);
        end
        push_event(k, p, 1'b0, '0);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        stim_row_t   plan[$];
        logic [39:0] p;
        int unsigned roll;
        int          t;
        int          steps;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        plan.push_back(row_want(KIND_TX_READY, pack_event(8'h00, 5'h00, 7'h00, 8'h00, 6'h00, 1'b0),
                                quiet_result(PH_IDLE)));
        plan.push_back(row_want(KIND_RX_BYTE, pack_event(8'hFF, 5'h1F, 7'h7F, 8'hFF, 6'h3F, 1'b1),
                                quiet_result(PH_IDLE)));
        plan.push_back(row_want(KIND_LOAD, pack_event(8'hFF, 5'h00, 7'h7F, 8'hFF, 6'h3F, 1'b1),
                                quiet_result(PH_IDLE)));
        plan.push_back(row_want(KIND_LOAD, pack_event(8'h00, 5'h1F, 7'h00, 8'h00, 6'h00, 1'b0),
                                quiet_result(PH_IDLE)));
        plan.push_back(row(KIND_LOAD, pack_event(8'hA5, 5'h01, 7'h00, 8'h00, 6'h00, 1'b0)));
        // two-byte write to the widest address and register
        plan.push_back(row_want(KIND_START, pack_event(8'h00, 5'h00, 7'h7F, 8'hFF, 6'd2, 1'b0),
                                start_result(7'h7F)));
        plan.push_back(row(KIND_TX_READY, pack_event(8'h00, 5'h00, 7'h00, 8'h00, 6'h00, 1'b0)));
        plan.push_back(row(KIND_TX_READY, pack_event(8'h00, 5'h00, 7'h00, 8'h00, 6'h00, 1'b0)));
        // a load mid-transaction touches only the buffer
        plan.push_back(row(KIND_LOAD, pack_event(8'h3C, 5'h05, 7'h00, 8'h00, 6'h00, 1'b0)));
        plan.push_back(row(KIND_TX_READY, pack_event(8'h00, 5'h00, 7'h00, 8'h00, 6'h00, 1'b0)));
        plan.push_back(row(KIND_TX_READY, pack_event(8'h00, 5'h00, 7'h00, 8'h00, 6'h00, 1'b0)));
        // zero-byte read falls through to a plain stop
        plan.push_back(row_want(KIND_START, pack_event(8'h00, 5'h00, 7'h00, 8'h00, 6'd0, 1'b1),
                                start_result(7'h00)));
        plan.push_back(row(KIND_TX_READY, pack_event(8'h00, 5'h00, 7'h00, 8'h00, 6'h00, 1'b0)));
        plan.push_back(row(KIND_TX_READY, pack_event(8'h00, 5'h00, 7'h00, 8'h00, 6'h00, 1'b0)));
        // single-byte read: stop goes out with the repeated start
        plan.push_back(row(KIND_START, pack_event(8'h00, 5'h00, 7'h55, 8'h12, 6'd1, 1'b1)));
        plan.push_back(row(KIND_TX_READY, pack_event(8'h00, 5'h00, 7'h00, 8'h00, 6'h00, 1'b0)));
        plan.push_back(row(KIND_TX_READY, pack_event(8'h00, 5'h00, 7'h00, 8'h00, 6'h00, 1'b0)));
        plan.push_back(row(KIND_TX_READY, pack_event(8'h00, 5'h00, 7'h00, 8'h00, 6'h00, 1'b0)));
        plan.push_back(row(KIND_RX_BYTE, pack_event(8'hFF, 5'h00, 7'h00, 8'h00, 6'h00, 1'b0)));
        // oversized read count saturates, then gets abandoned by a new start
        plan.push_back(row(KIND_START, pack_event(8'h00, 5'h00, 7'h2A, 8'h80, 6'd63, 1'b1)));
        plan.push_back(row(KIND_TX_READY, pack_event(8'h00, 5'h00, 7'h00, 8'h00, 6'h00, 1'b0)));
        plan.push_back(row(KIND_TX_READY, pack_event(8'h00, 5'h00, 7'h00, 8'h00, 6'h00, 1'b0)));
        plan.push_back(row(KIND_START, pack_event(8'h00, 5'h00, 7'h01, 8'h5A, 6'd0, 1'b0)));
        plan.push_back(row(KIND_RX_BYTE, pack_event(8'h00, 5'h00, 7'h00, 8'h00, 6'h00, 1'b0)));
        plan.push_back(row(KIND_TX_READY, pack_event(8'h00, 5'h00, 7'h00, 8'h00, 6'h00, 1'b0)));
        plan.push_back(row(KIND_TX_READY, pack_event(8'h00, 5'h00, 7'h00, 8'h00, 6'h00, 1'b0)));

        foreach (plan[i])
            push_event(plan[i].kind, plan[i].payload, plan[i].typed, plan[i].want);
        drain_results();

        t = 0;
        while (effective_events < ITEM_TARGET) begin
            // pause the sender until everything is out
            if (t == 35) drain_results();
            if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(20, 60);

            roll = $urandom_range(0, 99);
            if (roll < 30) begin
                repeat ($urandom_range(1, 3)) push_event(KIND_LOAD, rand_payload(), 1'b0, '0);
            end else if (roll < 38) begin
                push_event(roll[0] ? KIND_TX_READY : KIND_RX_BYTE, rand_payload(), 1'b0, '0);
            end

            p = rand_payload();
            roll = $urandom_range(0, 99);
            if (roll < 60)      p[33:28] = 6'($urandom_range(0, 4));
            else if (roll < 85) p[33:28] = 6'($urandom_range(5, 31));
            else if (roll < 95) p[33:28] = 6'd32;
            else                p[33:28] = 6'($urandom_range(33, 63));
            offer(KIND_START, p);

            steps = 0;
            while (seq_ph != PH_IDLE && steps < 200) begin
                steps++;
                roll = $urandom_range(0, 99);
                p = rand_payload();
                if (roll < 4)
                    offer(kind_t'($urandom_range(0, 3)), p);
                else if (seq_ph == PH_RX)
                    offer(KIND_RX_BYTE, p);
                else
                    offer(KIND_TX_READY, p);
            end
            t++;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("ran %0d events (%0d with effect), %0d transactions finished, %0d checked beats",
                 events_sent, effective_events, done_count, beats_seen);
        $display("%0d bytes put on the bus, %0d bytes delivered from it, %0d mismatches",
                 tx_bytes, rx_bytes, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin : result_sink
        int          stall_left;
        int          eager_left;
        int unsigned roll;
        stall_left = 0;
        eager_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                check_beat(m_tdata, m_tlast);
                // long hold-off so the event queue fills and intake stalls
                if (beats_seen % 300 == 150) stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (eager_left > 0) begin
                eager_left--;
                m_tready <= 1'b1;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 2) begin
                    eager_left = $urandom_range(50, 200);
                    m_tready <= 1'b1;
                end else if (roll < 72) begin
                    m_tready <= 1'b1;
                end else if (roll < 96) begin
                    stall_left = $urandom_range(0, 2);
                    m_tready <= 1'b0;
                end else begin
                    stall_left = $urandom_range(8, 30);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_results.size());
            $display("tb: failure");
            $finish;
        end
    end

endmodule
